// ----- rtl/core/bounded_substring_search_top_assert.svh -----
`ifndef BOUNDED_SUBSTRING_SEARCH_TOP_ASSERT_SVH
`define BOUNDED_SUBSTRING_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define BSS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bss_pkg.sv -----
package bss_pkg;

  localparam int unsigned PatBytes = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 4;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned StartW   = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgPatLow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPatHigh = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgPatLen  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgLimit   = CfgIdxW'(3);

  typedef struct packed {
    logic [PatBytes-1:0][ByteW-1:0] pattern;
    logic [LenW-1:0]                pat_len;
    logic [LimitW-1:0]              limit;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [StartW-1:0] match_start;
  } res_t;

endpackage

// ----- rtl/core/bss_if.sv -----
interface bss_text_if;
  import bss_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             final_byte;
  modport source (output valid, text_byte, final_byte, input ready);
  modport sink (input valid, text_byte, final_byte, output ready);
endinterface

interface bss_res_if;
  import bss_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [StartW-1:0] match_start;
  modport source (output valid, found, match_start, input ready);
  modport sink (input valid, found, match_start, output ready);
endinterface

interface bss_cfg_if;
  import bss_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/bss_cfg.sv -----
module bss_cfg #(
  parameter int unsigned MAX_PATTERN_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bss_cfg_if.sink       cfg_i,
  output bss_pkg::cfg_t cfg_o
);
  import bss_pkg::*;

  localparam int unsigned NumBytes =
    (MAX_PATTERN_BYTES < PatBytes) ? MAX_PATTERN_BYTES : PatBytes;

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q;
  logic [LenW-1:0]     len_q;
  logic [LimitW-1:0]   limit_q;
  logic [PatBytes-1:0][ByteW-1:0] pat_bytes;
  logic [LenW-1:0]     cap_len, eff_len;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      limit_q  <= '1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CfgPatLow:  pat_lo_q <= cfg_i.data;
        CfgPatHigh: pat_hi_q <= cfg_i.data;
        CfgPatLen:  len_q    <= cfg_i.data[LenW-1:0];
        CfgLimit:   limit_q  <= cfg_i.data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = {pat_hi_q, pat_lo_q};

  // a zero byte inside the pattern ends it
  always_comb begin
    cap_len = (len_q > LenW'(NumBytes)) ? LenW'(NumBytes) : len_q;
    eff_len = cap_len;
    for (int i = PatBytes - 1; i >= 0; i--) begin
      if (LenW'(i) < cap_len && pat_bytes[i] == '0) eff_len = LenW'(i);
    end
  end

  assign cfg_o.pattern = pat_bytes;
  assign cfg_o.pat_len = eff_len;
  assign cfg_o.limit   = limit_q;

endmodule

// ----- rtl/core/bss_match.sv -----
`include "bounded_substring_search_top_assert.svh"

module bss_match #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned POSITION_BITS     = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bss_text_if.sink      in_i,
  input  bss_pkg::cfg_t cfg_i,
  input  logic          out_free_i,
  output bss_pkg::res_t res_o
);
  import bss_pkg::*;

  localparam int unsigned NumBytes =
    (MAX_PATTERN_BYTES < PatBytes) ? MAX_PATTERN_BYTES : PatBytes;
  localparam int unsigned PosW = POSITION_BITS + 1;
  localparam int unsigned CmpW = (PosW > LimitW + 1) ? PosW : LimitW + 1;
  localparam logic [CmpW-1:0] MaxPos = CmpW'(1) << POSITION_BITS;

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_fin_q;
  logic [NumBytes-1:0] pm_q, pm_d, next_pm;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             dec_q, dec_d;
  logic             advance, s1_ends, hit, emit, found, clear;
  logic [CmpW-1:0]  lim_raw, lim, pos_ext, start_full;

  assign advance    = s1_valid_q && out_free_i;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.text_byte;
      s1_fin_q  <= in_i.final_byte;
    end
  end

  assign s1_ends = (s1_byte_q == '0) || s1_fin_q;
  assign lim_raw = CmpW'(cfg_i.limit);
  assign lim     = (lim_raw > MaxPos) ? MaxPos : lim_raw;
  assign pos_ext = CmpW'(pos_q);

  always_comb begin
    next_pm = '0;
    hit     = 1'b0;
    for (int i = 0; i < NumBytes; i++) begin
      if (LenW'(i) < cfg_i.pat_len && s1_byte_q == cfg_i.pattern[i]) begin
        if (i == 0) next_pm[i] = pos_ext < lim;
        else        next_pm[i] = pm_q[(i == 0) ? 0 : i - 1];
      end
      if (LenW'(i + 1) == cfg_i.pat_len && next_pm[i]) hit = 1'b1;
    end
  end

  assign start_full = pos_ext - CmpW'(cfg_i.pat_len) + CmpW'(1);

  always_comb begin
    pm_d  = pm_q;
    pos_d = pos_q;
    dec_d = dec_q;
    emit  = 1'b0;
    found = 1'b0;
    clear = 1'b0;
    if (dec_q) begin
      clear = s1_ends;
    end else if (cfg_i.pat_len == '0) begin
      emit  = 1'b1;
      found = 1'b1;
      clear = s1_ends;
      dec_d = 1'b1;
    end else if (lim == '0) begin
      emit  = 1'b1;
      clear = s1_ends;
      dec_d = 1'b1;
    end else if (s1_byte_q == '0) begin
      emit  = 1'b1;
      clear = 1'b1;
    end else begin
      pm_d = next_pm;
      if (hit) begin
        emit  = 1'b1;
        found = 1'b1;
        clear = s1_fin_q;
        dec_d = 1'b1;
      end else if (next_pm == '0 && pos_ext + CmpW'(1) >= lim) begin
        emit  = 1'b1;
        clear = s1_fin_q;
        dec_d = 1'b1;
      end else if (s1_fin_q) begin
        emit  = 1'b1;
        clear = 1'b1;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
    if (clear) begin
      pm_d  = '0;
      pos_d = '0;
      dec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q  <= '0;
      pos_q <= '0;
      dec_q <= 1'b0;
    end else if (advance) begin
      pm_q  <= pm_d;
      pos_q <= pos_d;
      dec_q <= dec_d;
    end
  end

  assign res_o.valid       = advance && emit;
  assign res_o.found       = found;
  assign res_o.match_start =
    (found && cfg_i.pat_len != '0) ? start_full[StartW-1:0] : '0;

  `BSS_ASSERT_NOW(a_notfound_zero, clk_i, rst_ni, res_o.valid && !res_o.found, res_o.match_start == '0, "not-found result with nonzero start")
  `BSS_ASSERT_NEXT(a_decided_after_res, clk_i, rst_ni, res_o.valid && !s1_ends, dec_q, "result without end of string left search open")
  `BSS_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, advance && dec_q && s1_ends, !dec_q && pos_q == '0 && pm_q == '0, "end of string after decision did not clear state")
  `BSS_ASSERT_NOW(a_no_res_when_decided, clk_i, rst_ni, advance && dec_q, !res_o.valid, "result produced after decision")

endmodule

// ----- rtl/core/bounded_substring_search_top.sv -----
// channel  dir  payload                      accepted when
// in_i     in   text_byte[7:0], final_byte   in_i.valid && in_i.ready
// res_o    out  found, match_start[15:0]     res_o.valid && res_o.ready
// cfg_i    in   index[7:0], data[31:0]       cfg_i.valid && cfg_i.ready (always ready)
//
// One byte per cycle sustained while the result channel is not stalled; a result is registered
// on its way through input register, one pass of compare logic, output register.
// Reset clears the search state and loads the register defaults (limit all ones).
// A stalled result holds the output register; the input stage keeps taking a byte
// as long as the output register is free or being emptied.
module bounded_substring_search_top #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned POSITION_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bss_text_if.sink   in_i,
  bss_res_if.source  res_o,
  bss_cfg_if.sink    cfg_i
);
  import bss_pkg::*;

  cfg_t              cfg;
  res_t              res_next;
  logic              out_free;
  logic              res_valid_q;
  logic              found_q;
  logic [StartW-1:0] start_q;

  bss_cfg #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_i,
    .cfg_o(cfg)
  );

  bss_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .POSITION_BITS(POSITION_BITS)
  ) u_match (
    .clk_i,
    .rst_ni,
    .in_i,
    .cfg_i(cfg),
    .out_free_i(out_free),
    .res_o(res_next)
  );

  assign out_free = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= res_next.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_next.valid) begin
      found_q <= res_next.found;
      start_q <= res_next.match_start;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.found       = found_q;
  assign res_o.match_start = start_q;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bss_pkg::*;

  localparam int ITEMS        = 1600;
  localparam int PHASES       = 24;
  localparam int DRAIN_CYCLES = 6;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;

  class match_tracker;
    typedef struct packed {
      logic              found;
      logic [StartW-1:0] start;
    } verdict_t;

    logic [CfgDataW-1:0] pat_lo;
    logic [CfgDataW-1:0] pat_hi;
    logic [LenW-1:0]     pat_len;
    logic [LimitW-1:0]   limit;
    logic [PatBytes-1:0] live;
    int unsigned         pos;
    bit                  decided;
    verdict_t            verdicts[$];
    int                  errors;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      limit = '1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      live = '0;
      pos = 0;
      decided = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgPatLow:  pat_lo = data;
        CfgPatHigh: pat_hi = data;
        CfgPatLen:  pat_len = data[LenW-1:0];
        CfgLimit:   limit = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ByteW-1:0] pat_byte(int unsigned i);
      logic [CfgDataW-1:0] w;
      w = (i < 4) ? pat_lo : pat_hi;
      return w[(i % 4) * 8 +: 8];
    endfunction

    // length saturates at eight and stops at the first zero byte
    function int eff_len();
      int n;
      n = (pat_len > PatBytes) ? PatBytes : pat_len;
      for (int i = 0; i < n; i++) begin
        if (pat_byte(i) == '0) return i;
      end
      return n;
    endfunction

    function void post_verdict(bit ends, logic found, logic [StartW-1:0] start);
      verdict_t v;
      v.found = found;
      v.start = start;
      verdicts.push_back(v);
      if (ends) restart();
      else decided = 1'b1;
    endfunction

    // returns 1 when the byte was not ignored
    function bit take_byte(logic [ByteW-1:0] b, bit fin);
      bit ends;
      int n;
      logic [PatBytes-1:0] nxt;
      ends = (b == '0) || fin;
      if (decided) begin
        if (ends) restart();
        return 1'b0;
      end
      n = eff_len();
      if (n == 0) begin
        post_verdict(ends, 1'b1, '0);
        return 1'b1;
      end
      if (limit == '0) begin
        post_verdict(ends, 1'b0, '0);
        return 1'b1;
      end
      if (b == '0) begin
        post_verdict(1'b1, 1'b0, '0);
        return 1'b1;
      end
      nxt = '0;
      if (pos < limit && b == pat_byte(0)) nxt[0] = 1'b1;
      for (int i = 1; i < n; i++) begin
        if (live[i-1] && b == pat_byte(i)) nxt[i] = 1'b1;
      end
      live = nxt;
      if (live[n-1]) post_verdict(fin, 1'b1, StartW'(pos - (n - 1)));
      else if (live == '0 && pos + 1 >= limit) post_verdict(fin, 1'b0, '0);
      else if (fin) post_verdict(1'b1, 1'b0, '0);
      else pos++;
      return 1'b1;
    endfunction

    function void check_verdict(logic found, logic [StartW-1:0] start);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: result with none expected, found %0b start %0d", $time, found, start);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, found);
        errors++;
      end
      if (start !== want.start) begin
        $display("%0t: match_start expected %0d actual %0d", $time, want.start, start);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void close_out();
      if (verdicts.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, verdicts.size());
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bss_text_if text_if ();
  bss_res_if  res_if ();
  bss_cfg_if  cfg_if ();

  bounded_substring_search_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  match_tracker tracker = new();

  int         send_idle_pct = 10;
  int         recv_idle_pct = 57;
  int         live_items = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;
  logic [7:0] alpha [3] = '{8'h61, 8'h62, 8'h63};

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) tracker.check_verdict(res_if.found, res_if.match_start);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_text(input logic [ByteW-1:0] b, input bit fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= b;
    text_if.final_byte <= fin;
    do @(posedge clk_i); while (!text_if.ready);
    void'(tracker.take_byte(b, fin));
    live_items++;
  endtask

  task automatic send_word(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_text(s[i], fin_last && i == s.len() - 1);
    end
  endtask

  task automatic settle();
    text_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_reg(idx, data);
  endtask

  task automatic load_cfg(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                          input logic [LenW-1:0] len, input logic [LimitW-1:0] lim);
    settle();
    write_reg(CfgPatLow, lo);
    write_reg(CfgPatHigh, hi);
    write_reg(CfgPatLen, CfgDataW'({$urandom, len}));
    write_reg(CfgLimit, CfgDataW'({$urandom, lim}));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] b;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) b = alpha[$urandom_range(0, 2)];
    else if (r < 85) b = tracker.pat_byte($urandom_range(0, 7));
    else b = ByteW'($urandom_range(1, 255));
    if (b == '0) b = alpha[0];
    return b;
  endfunction

  task automatic random_cfg(input int phase);
    logic [ByteW-1:0]  pb [PatBytes];
    logic [LenW-1:0]   len;
    logic [LimitW-1:0] lim;
    int r;
    if ($urandom_range(0, 4) == 0) begin
      foreach (alpha[i]) alpha[i] = ByteW'($urandom_range(1, 255));
    end else begin
      foreach (alpha[i]) alpha[i] = 8'h61 + ByteW'(i);
    end
    foreach (pb[i]) begin
      r = $urandom_range(0, 99);
      if (r < 85) pb[i] = alpha[$urandom_range(0, 2)];
      else if (r < 95) pb[i] = ByteW'($urandom_range(1, 255));
      else pb[i] = '0;
    end
    r = $urandom_range(0, 19);
    if (r == 0) len = '0;
    else if (r < 17) len = LenW'($urandom_range(1, 8));
    else len = LenW'($urandom_range(9, 15));
    case ($urandom_range(0, 9))
      0: lim = '0;
      1: lim = LimitW'(1);
      2: lim = '1;
      3: lim = LimitW'($urandom);
      default: lim = LimitW'($urandom_range(2, 20));
    endcase
    if (phase == 0) begin
      alpha = '{8'hFF, 8'hFF, 8'hFE};
      foreach (pb[i]) pb[i] = 8'hFF;
      len = '1;
      lim = '1;
    end
    load_cfg({pb[3], pb[2], pb[1], pb[0]}, {pb[7], pb[6], pb[5], pb[4]}, len, lim);
  endtask

  // mostly: filler, a copy of the pattern (sometimes cut short), filler, terminator
  task automatic send_random_string();
    int head;
    int body;
    int tail;
    int total;
    bit zero_end;
    logic [ByteW-1:0] b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        send_text(ByteW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
      return;
    end
    head = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
    body = tracker.eff_len();
    if (body > 0 && $urandom_range(0, 4) == 0) body = $urandom_range(0, body - 1);
    tail = $urandom_range(0, 5);
    total = head + body + tail;
    zero_end = (total == 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < total; i++) begin
      if (i >= head && i < head + body) b = tracker.pat_byte(i - head);
      else b = pick_byte();
      send_text(b, !zero_end && i == total - 1);
    end
    if (zero_end) send_text('0, $urandom_range(0, 1) == 1);
  endtask

  initial begin
    int target;
    rst_ni             <= 1'b0;
    text_if.valid      <= 1'b0;
    text_if.text_byte  <= '0;
    text_if.final_byte <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern after reset, with a zero byte and with a final byte
    send_text(8'h00, 1'b0);
    send_text(8'h41, 1'b1);
    // empty pattern wins over a zero limit
    load_cfg('0, '0, 4'd0, 16'd0);
    send_text(8'h00, 1'b0);
    // zero limit, later bytes ignored
    load_cfg(32'h0000_6261, '0, 4'd2, 16'd0);
    send_word("ab", 1'b1);
    // overlapping prefixes, match on the final byte
    load_cfg(32'h0062_6161, '0, 4'd3, 16'd3);
    send_word("aaab", 1'b1);
    // match runs past the limit; then starts exhausted
    load_cfg(32'h0000_6261, '0, 4'd2, 16'd2);
    send_word("xab", 1'b0);
    send_text(8'h00, 1'b0);
    send_word("xyz", 1'b0);
    send_text(8'h00, 1'b0);
    // zero byte ends the string; final byte compared first
    load_cfg(32'h0000_6261, '0, 4'd2, 16'hFFFF);
    send_word("a", 1'b0);
    send_text(8'h00, 1'b0);
    send_word("ab", 1'b1);
    send_word("x", 1'b1);
    // oversized length with a zero byte inside the pattern
    load_cfg(32'h0063_6261, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
    send_word("abc", 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      random_cfg(phase);
      if (phase < PHASES / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 57;
      end else if (phase < 2 * PHASES / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 2 * PHASES / 3) hold_req = 1'b1;
      target = live_items + ITEMS / PHASES;
      while (live_items < target) send_random_string();
    end

    settle();
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- bounded_substring_search_top.f -----
+incdir+rtl/core
rtl/core/bss_pkg.sv
rtl/core/bss_if.sv
rtl/core/bss_cfg.sv
rtl/core/bss_match.sv
rtl/core/bounded_substring_search_top.sv
dv/tb_top.sv
